// ===== rtl/lctsu_pkg.sv =====
// shared types and constants for the load cell tare and scale unit
// holds status and operation codes, reset values and the divider beat structs
// no dependencies
package lctsu_pkg;

    localparam int DIVIDEND_W = 33;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] FUNC_WEIGH = 2'd0;
    localparam logic [1:0] FUNC_TARE  = 2'd1;
    localparam logic [1:0] FUNC_CAL   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TARE_BUSY = 3'd1;
    localparam logic [2:0] ST_TARE_DONE = 3'd2;
    localparam logic [2:0] ST_SATURATED = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd4;

    localparam logic signed [31:0] OFFSET_RESET = -32'sd58209;
    localparam logic signed [31:0] SCALE_RESET  = 32'sd402;
    localparam logic [7:0]         COUNT_RESET  = 8'd16;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/lctsu_div.sv =====
// shared unsigned restoring divider, one quotient bit per cycle
// depends on lctsu_pkg for widths and the request and response structs
module lctsu_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  lctsu_pkg::div_req_t req,
    output lctsu_pkg::div_rsp_t rsp
);

    logic [lctsu_pkg::DIVIDEND_W-1:0] dq_reg;
    logic [lctsu_pkg::DIVIDEND_W-1:0] dq_next;
    logic [lctsu_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [lctsu_pkg::DIVISOR_W-1:0]  rem_next;
    logic [lctsu_pkg::DIVISOR_W-1:0]  dvs_reg;
    logic [lctsu_pkg::DIVISOR_W-1:0]  dvs_next;
    logic [lctsu_pkg::STEP_W-1:0]     cnt_reg;
    logic [lctsu_pkg::STEP_W-1:0]     cnt_next;
    logic                             done_reg;
    logic                             done_next;
    logic [lctsu_pkg::DIVISOR_W:0]    trial;
    logic [lctsu_pkg::DIVISOR_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[lctsu_pkg::DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dq_next  = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = lctsu_pkg::STEP_W'(lctsu_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[lctsu_pkg::DIVISOR_W-1:0];
                dq_next  = {dq_reg[lctsu_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[lctsu_pkg::DIVISOR_W-1:0];
                dq_next  = {dq_reg[lctsu_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == lctsu_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

// ===== rtl/load_cell_tare_scale_unit_core.sv =====
// top level of the load cell tare and scale unit: sequencer, state and output register
// depends on lctsu_pkg and lctsu_div
//
// usage:
//   input channel (in_valid / in_stall) carries func, raw_sample and known_weight.
//   output channel (out_valid / out_stall) returns one value and status per input beat.
//   config channel (cfg_valid / cfg_ready) writes tare_sample_count; ready is always high,
//   writes must be made only while the unit is idle; the unit itself does not enforce this.
//   weigh, calibrate and the final tare sample run the shared divider when its divisor is
//   nonzero, going through S_PREP, S_DIV, S_FIN and then S_OUT to load the output register;
//   other cases go from S_PREP straight to S_OUT.
//   one item is handled at a time; in_stall stays high from accept until the
//   result has moved into the output register, so the divider loop sets the rate.
//   the output register holds a result while out_stall is high; the next input beat
//   may be accepted meanwhile, and its result waits until the register is free.
//   reset: offset -58209, scale 402, tare accumulator cleared, sample count 16,
//   no output valid.
module load_cell_tare_scale_unit_core
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [23:0] raw_sample,
    input  logic [15:0]        known_weight,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [2:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_FIN, S_OUT} state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 func_reg, func_next;
    logic [23:0]                raw_reg, raw_next;
    logic [15:0]                weight_reg, weight_next;
    logic signed [31:0]         offset_reg, offset_next;
    logic signed [31:0]         scale_reg, scale_next;
    logic signed [31:0]         tare_sum_reg, tare_sum_next;
    logic [7:0]                 tare_seen_reg, tare_seen_next;
    logic [7:0]                 count_reg, count_next;
    logic                       neg_reg, neg_next;
    logic [31:0]                res_value_reg, res_value_next;
    logic [2:0]                 res_status_reg, res_status_next;
    logic                       out_valid_reg, out_valid_next;
    logic [31:0]                out_value_reg, out_value_next;
    logic [2:0]                 out_status_reg, out_status_next;

    lctsu_pkg::div_req_t        div_req;
    lctsu_pkg::div_rsp_t        div_rsp;

    logic signed [32:0]         sample_ext;
    logic signed [32:0]         diff;
    logic [32:0]                diff_mag;
    logic [31:0]                scale_mag;
    logic signed [31:0]         sum_new;
    logic [31:0]                sum_mag;
    logic [7:0]                 seen_new;
    logic signed [33:0]         quot_s;

    lctsu_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample_ext = 33'($signed(raw_reg[SAMPLE_BITS-1:0]));
    assign diff       = sample_ext - 33'(offset_reg);
    assign diff_mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign scale_mag  = scale_reg[31] ? 32'(-scale_reg) : 32'(scale_reg);
    assign sum_new    = tare_sum_reg + $signed(sample_ext[31:0]);
    assign sum_mag    = sum_new[31] ? 32'(-sum_new) : 32'(sum_new);
    assign seen_new   = tare_seen_reg + 8'd1;
    assign quot_s     = neg_reg ? -$signed({1'b0, div_rsp.quotient})
                                : $signed({1'b0, div_rsp.quotient});

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        raw_next        = raw_reg;
        weight_next     = weight_reg;
        offset_next     = offset_reg;
        scale_next      = scale_reg;
        tare_sum_next   = tare_sum_reg;
        tare_seen_next  = tare_seen_reg;
        count_next      = count_reg;
        neg_next        = neg_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        div_req.start    = 1'b0;
        div_req.dividend = diff_mag;
        div_req.divisor  = scale_mag;

        if (cfg_valid)
        begin
            count_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func;
                    raw_next    = raw_sample;
                    weight_next = known_weight;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                res_value_next  = '0;
                res_status_next = lctsu_pkg::ST_OK;
                state_next      = S_OUT;
                case (func_reg)
                    lctsu_pkg::FUNC_WEIGH:
                    begin
                        if (scale_reg == '0)
                        begin
                            res_status_next = lctsu_pkg::ST_DIV_ZERO;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            neg_next      = diff[32] ^ scale_reg[31];
                            state_next    = S_DIV;
                        end
                    end
                    lctsu_pkg::FUNC_TARE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = lctsu_pkg::ST_DIV_ZERO;
                        end
                        else if (seen_new >= count_reg)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {1'b0, sum_mag};
                            div_req.divisor  = {24'd0, seen_new};
                            neg_next         = sum_new[31];
                            tare_sum_next    = '0;
                            tare_seen_next   = '0;
                            state_next       = S_DIV;
                        end
                        else
                        begin
                            tare_sum_next   = sum_new;
                            tare_seen_next  = seen_new;
                            res_status_next = lctsu_pkg::ST_TARE_BUSY;
                        end
                    end
                    lctsu_pkg::FUNC_CAL:
                    begin
                        if (weight_reg == '0)
                        begin
                            res_status_next = lctsu_pkg::ST_DIV_ZERO;
                        end
                        else
                        begin
                            div_req.start   = 1'b1;
                            div_req.divisor = {16'd0, weight_reg};
                            neg_next        = diff[32];
                            state_next      = S_DIV;
                        end
                    end
                    default:
                    begin
                        res_status_next = lctsu_pkg::ST_OK;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next      = S_OUT;
                res_value_next  = quot_s[31:0];
                res_status_next = lctsu_pkg::ST_OK;
                case (func_reg)
                    lctsu_pkg::FUNC_WEIGH:
                    begin
                        if (quot_s > 34'sd32767)
                        begin
                            res_value_next  = 32'sd32767;
                            res_status_next = lctsu_pkg::ST_SATURATED;
                        end
                        else if (quot_s < -34'sd32768)
                        begin
                            res_value_next  = -32'sd32768;
                            res_status_next = lctsu_pkg::ST_SATURATED;
                        end
                        else
                        begin
                            res_value_next = {{16{quot_s[15]}}, quot_s[15:0]};
                        end
                    end
                    lctsu_pkg::FUNC_TARE:
                    begin
                        offset_next     = quot_s[31:0];
                        res_status_next = lctsu_pkg::ST_TARE_DONE;
                    end
                    lctsu_pkg::FUNC_CAL:
                    begin
                        scale_next = quot_s[31:0];
                    end
                    default:
                    begin
                        res_value_next = '0;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            offset_reg     <= lctsu_pkg::OFFSET_RESET;
            scale_reg      <= lctsu_pkg::SCALE_RESET;
            tare_sum_reg   <= '0;
            tare_seen_reg  <= '0;
            count_reg      <= lctsu_pkg::COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            offset_reg     <= offset_next;
            scale_reg      <= scale_next;
            tare_sum_reg   <= tare_sum_next;
            tare_seen_reg  <= tare_seen_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        raw_reg        <= raw_next;
        weight_reg     <= weight_next;
        neg_reg        <= neg_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;

    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // an accepted beat blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // a new result is only loaded from the output state
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output loaded outside output state");

    // a final tare has cleared the tare count by the time it reaches the fix-up state
    a_seen_cleared_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && func_reg == lctsu_pkg::FUNC_TARE) |-> (tare_seen_reg == '0))
        else $error("tare count not cleared at tare end");

endmodule

// ===== test/tb_top.sv =====
// testbench for the load cell tare and scale unit: directed and random beats checked
// against an in-bench model of weigh, tare and calibrate, with random idling and stalls
// depends on lctsu_pkg and load_cell_tare_scale_unit_core
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [23:0] sample;
        logic [15:0]        weight;
    } meas_beat_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } meas_reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = '0;
    logic signed [23:0] raw_sample = '0;
    logic [15:0]        known_weight = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] value;
    logic [2:0]         status;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data = '0;

    meas_beat_t    pending_beats[$];
    meas_reading_t expected_readings[$];
    meas_beat_t    cur_beat;
    meas_reading_t new_reading;
    meas_reading_t want;
    logic          offering;

    // model state
    logic signed [31:0] pred_offset = lctsu_pkg::OFFSET_RESET;
    logic signed [31:0] pred_scale = lctsu_pkg::SCALE_RESET;
    longint             pred_tare_sum = 0;
    int                 pred_tare_seen = 0;
    int                 pred_count = int'(lctsu_pkg::COUNT_RESET);

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_off = 1'b0;
    bit  pressure_go = 1'b0;

    int errors = 0;
    int beats_sent = 0;
    int readings_checked = 0;
    int tares_done = 0;
    int saturations = 0;
    int div_zeros = 0;

    load_cell_tare_scale_unit_core #(.SAMPLE_BITS(24)) DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .raw_sample   (raw_sample),
        .known_weight (known_weight),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic compute_reading(input meas_beat_t b, output meas_reading_t r);
        longint diff;
        longint q;
        diff = longint'($signed(b.sample)) - longint'(pred_offset);
        r.value = '0;
        r.status = lctsu_pkg::ST_OK;
        case (b.func)
            lctsu_pkg::FUNC_WEIGH:
            begin
                if (pred_scale == 0)
                    r.status = lctsu_pkg::ST_DIV_ZERO;
                else
                begin
                    q = diff / longint'(pred_scale);
                    if (q > 32767)
                    begin
                        r.value = 32'sd32767;
                        r.status = lctsu_pkg::ST_SATURATED;
                    end
                    else if (q < -32768)
                    begin
                        r.value = -32'sd32768;
                        r.status = lctsu_pkg::ST_SATURATED;
                    end
                    else
                        r.value = 32'(q);
                end
            end
            lctsu_pkg::FUNC_TARE:
            begin
                if (pred_count == 0)
                    r.status = lctsu_pkg::ST_DIV_ZERO;
                else
                begin
                    pred_tare_sum += longint'($signed(b.sample));
                    pred_tare_seen++;
                    if (pred_tare_seen >= pred_count)
                    begin
                        pred_offset = 32'(pred_tare_sum / longint'(pred_tare_seen));
                        pred_tare_sum = 0;
                        pred_tare_seen = 0;
                        r.value = pred_offset;
                        r.status = lctsu_pkg::ST_TARE_DONE;
                    end
                    else
                        r.status = lctsu_pkg::ST_TARE_BUSY;
                end
            end
            lctsu_pkg::FUNC_CAL:
            begin
                if (b.weight == 16'd0)
                    r.status = lctsu_pkg::ST_DIV_ZERO;
                else
                begin
                    pred_scale = 32'(diff / longint'(b.weight));
                    r.value = pred_scale;
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("mismatch at %0t: %s got %0d wanted %0d", $time, what, got, exp_val);
        errors++;
    endtask

    task automatic queue_beat(input logic [1:0] f, input logic [23:0] s, input logic [15:0] w);
        meas_beat_t b;
        b.func = f;
        b.sample = s;
        b.weight = w;
        pending_beats.push_back(b);
    endtask

    function automatic logic [23:0] pick_sample(input int centre, input int span);
        case ($urandom_range(7))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2, 3: return 24'($urandom);
            default: return 24'(centre + int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    task automatic write_count(input logic [7:0] c);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pred_count = int'(c);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input beat driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= '0;
            raw_sample <= '0;
            known_weight <= '0;
        end
        else
        begin
            offering = in_valid;
            if (in_valid && !in_stall)
            begin
                compute_reading(cur_beat, new_reading);
                expected_readings.push_back(new_reading);
                beats_sent++;
                offering = 1'b0;
            end
            if (!offering && pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_beat = pending_beats.pop_front();
                func <= cur_beat.func;
                raw_sample <= cur_beat.sample;
                known_weight <= cur_beat.weight;
                offering = 1'b1;
            end
            in_valid <= offering;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("reading with nothing expected, value", value, 0);
                else
                begin
                    want = expected_readings.pop_front();
                    if (value !== want.value)
                        report_mismatch("value", value, want.value);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    readings_checked++;
                    if (want.status == lctsu_pkg::ST_TARE_DONE)
                        tares_done++;
                    if (want.status == lctsu_pkg::ST_SATURATED)
                        saturations++;
                    if (want.status == lctsu_pkg::ST_DIV_ZERO)
                        div_zeros++;
                end
            end
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // long receiver hold-off so the output register and then the input back up
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int counts [8];
        int centre;
        int added;
        int len;
        int tare_len;
        logic [15:0] w;

        counts = '{4, 255, 1, 2, 7, 255, 16, 3};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_count(8'd3);
        // reset offset and scale, then divide by zero, zero scale and saturation
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'd0, 16'd0);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'h7fffff, 16'hffff);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'h800000, 16'd0);
        queue_beat(FUNC_NONE, 24'h7fffff, 16'hffff);
        queue_beat(lctsu_pkg::FUNC_CAL, 24'd123, 16'd0);
        queue_beat(lctsu_pkg::FUNC_CAL, 24'(-58204), 16'hffff);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'd0, 16'd1);
        queue_beat(lctsu_pkg::FUNC_CAL, 24'(-58208), 16'd1);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'h7fffff, 16'd0);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'h800000, 16'd0);
        queue_beat(lctsu_pkg::FUNC_CAL, 24'h800000, 16'd3);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'h7fffff, 16'd0);
        // tare with other operations mixed in
        queue_beat(lctsu_pkg::FUNC_TARE, 24'h7fffff, 16'd0);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'd1000, 16'd0);
        queue_beat(lctsu_pkg::FUNC_TARE, 24'h7fffff, 16'd0);
        queue_beat(lctsu_pkg::FUNC_CAL, 24'd1000, 16'd400);
        queue_beat(lctsu_pkg::FUNC_TARE, 24'h7fffff, 16'd0);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'h800000, 16'd0);
        queue_beat(lctsu_pkg::FUNC_TARE, 24'h800000, 16'd0);
        queue_beat(lctsu_pkg::FUNC_TARE, 24'h800000, 16'd0);
        wait_drained();

        // count lowered part way through a tare
        write_count(8'd1);
        queue_beat(lctsu_pkg::FUNC_TARE, 24'h800000, 16'd0);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'd0, 16'd0);
        wait_drained();

        // zero sample count
        write_count(8'd0);
        queue_beat(lctsu_pkg::FUNC_TARE, 24'd5, 16'd0);
        queue_beat(lctsu_pkg::FUNC_WEIGH, 24'h7fffff, 16'd0);
        queue_beat(lctsu_pkg::FUNC_CAL, 24'h7fffff, 16'hffff);
        wait_drained();

        for (int i = 0; i < 8; i++)
        begin
            write_count(8'(counts[i]));
            case (i % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            if (i == 0)
                pressure_go = 1'b1;
            centre = int'($urandom_range(32'h40_0000)) - 32'h20_0000;
            tare_len = (counts[i] <= 16) ? counts[i] : int'($urandom_range(1, 40));
            added = 0;
            while (added < 118)
            begin
                case ($urandom_range(9))
                    0, 1, 2:
                    begin
                        repeat (tare_len)
                            queue_beat(lctsu_pkg::FUNC_TARE, pick_sample(centre, 255),
                                       16'($urandom));
                        added += tare_len;
                    end
                    3, 4:
                    begin
                        w = 16'($urandom_range(1, 2000));
                        queue_beat(lctsu_pkg::FUNC_CAL,
                                   24'(centre + int'(w) * int'($urandom_range(1, 2000))), w);
                        len = $urandom_range(2, 6);
                        repeat (len)
                            queue_beat(lctsu_pkg::FUNC_WEIGH, pick_sample(centre, 1 << 20),
                                       16'($urandom));
                        added += len + 1;
                    end
                    5, 6, 7:
                    begin
                        len = $urandom_range(3, 8);
                        repeat (len)
                            queue_beat(lctsu_pkg::FUNC_WEIGH, pick_sample(centre, 1 << 16),
                                       16'($urandom));
                        added += len;
                    end
                    8:
                    begin
                        len = $urandom_range(1, 3);
                        repeat (len)
                            queue_beat(2'($urandom), 24'($urandom), 16'($urandom));
                        added += len;
                    end
                    default:
                    begin
                        if ($urandom_range(1))
                            queue_beat(FUNC_NONE, 24'($urandom), 16'($urandom));
                        else
                            queue_beat(lctsu_pkg::FUNC_CAL, pick_sample(centre, 4095), 16'd0);
                        added += 1;
                    end
                endcase
            end
            wait_drained();
        end

        $display("covered %0d beats and %0d readings over 11 phases of count and idling",
                 beats_sent, readings_checked);
        $display("completed tares %0d, saturated weighs %0d, divide by zero %0d",
                 tares_done, saturations, div_zeros);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lctsu_pkg.sv
rtl/lctsu_div.sv
rtl/load_cell_tare_scale_unit_core.sv
test/tb_top.sv
